// ===== rtl/tccw_pkg.sv =====
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ADDR_W   = 11;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned CELL_W   = CHAR_W + ATTR_W;

  localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  // Register indexes on the configuration port.
  localparam logic REG_BACKGROUND = 1'b0;
  localparam logic REG_FOREGROUND = 1'b1;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_NOP,
    KIND_NEWLINE,
    KIND_BACKSPACE,
    KIND_PRINT
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [CHAR_W-1:0]   character;
    logic [ADDR_W-1:0]   cell_address;
  } q_item_t;

endpackage

// ===== rtl/tccw_if.sv =====
`timescale 1ns / 1ps

interface tccw_in_if;
  logic                            valid;
  logic                            ready;
  logic [tccw_pkg::OPCODE_W-1:0]   opcode;
  logic [tccw_pkg::CHAR_W-1:0]     character;
  logic [tccw_pkg::ADDR_W-1:0]     cell_address;

  modport source (output valid, output opcode, output character, output cell_address,
                  input ready);
  modport sink (input valid, input opcode, input character, input cell_address,
                output ready);
endinterface

interface tccw_out_if;
  logic                            valid;
  logic                            ready;
  logic [tccw_pkg::COL_W-1:0]      cursor_column;
  logic [tccw_pkg::ROW_W-1:0]      cursor_row;
  logic                            scrolled;
  logic [tccw_pkg::CHAR_W-1:0]     read_character;
  logic [tccw_pkg::ATTR_W-1:0]     read_attribute;

  modport source (output valid, output cursor_column, output cursor_row, output scrolled,
                  output read_character, output read_attribute, input ready);
  modport sink (input valid, input cursor_column, input cursor_row, input scrolled,
                input read_character, input read_attribute, output ready);
endinterface

// ===== rtl/tccw_front.sv =====
`timescale 1ns / 1ps

module tccw_front (
  input  logic              clk,
  input  logic              rst_n,
  tccw_in_if.sink           in_ch,
  input  logic              hold_off,
  output logic              q_valid,
  output tccw_pkg::q_item_t q_item,
  input  logic              q_pop
);

  tccw_pkg::q_item_t q_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push;
  tccw_pkg::q_item_t new_item;

  assign in_ch.ready = (cnt_r != 2'd2) && !hold_off;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = q_r[rd_ptr_r];

  always_comb begin
    new_item.character    = in_ch.character;
    new_item.cell_address = in_ch.cell_address;
    if (in_ch.opcode == tccw_pkg::OP_READ) begin
      new_item.kind = tccw_pkg::KIND_READ;
    end else begin
      case (in_ch.character)
        tccw_pkg::CHAR_NUL:       new_item.kind = tccw_pkg::KIND_NOP;
        tccw_pkg::CHAR_NEWLINE,
        tccw_pkg::CHAR_RETURN:    new_item.kind = tccw_pkg::KIND_NEWLINE;
        tccw_pkg::CHAR_BACKSPACE: new_item.kind = tccw_pkg::KIND_BACKSPACE;
        default:                  new_item.kind = tccw_pkg::KIND_PRINT;
      endcase
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== rtl/tccw_back.sv =====
`timescale 1ns / 1ps

module tccw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  tccw_pkg::q_item_t            q_item,
  output logic                         q_pop,
  input  logic [tccw_pkg::ATTR_W-1:0]  attribute,
  output logic                         clearing,
  tccw_out_if.source                   out_ch
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned LAST  = (ROWS - 1) * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_BLANK  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] sc_r, sc_nxt;
  logic          wv_r, wv_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          res_scrolled_r, res_scrolled_nxt;
  logic          res_read_r, res_read_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [tccw_pkg::COL_W-1:0]    out_col_r;
  logic [tccw_pkg::ROW_W-1:0]    out_row_r;
  logic                          out_scr_r;
  logic [tccw_pkg::CHAR_W-1:0]   out_ch_r;
  logic [tccw_pkg::ATTR_W-1:0]   out_at_r;
  logic                          out_load;

  logic [tccw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tccw_pkg::CELL_W-1:0] rdata_r;
  logic                        we, re;
  logic [AW-1:0]               wa, ra;
  logic [tccw_pkg::CELL_W-1:0] wd;

  logic [AW-1:0]               cur_addr;
  logic [AW-1:0]               back_addr;
  logic [CW-1:0]               back_col;
  logic [RW-1:0]               back_row;
  logic [tccw_pkg::CELL_W-1:0] blank;

  assign clearing      = (state_r == ST_CLEAR);
  assign blank         = {attribute, tccw_pkg::CHAR_SPACE};
  assign cur_addr      = AW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign out_load      = (state_r == ST_RESULT) && (!out_valid_r || out_ch.ready);

  // Backspace target: one step back, wrapping to the previous row and
  // clamping at the top-left cell.
  always_comb begin
    back_col = col_r;
    back_row = row_r;
    if (col_r != '0) begin
      back_col = col_r - CW'(1);
    end else if (row_r != '0) begin
      back_col = CW'(COLUMNS - 1);
      back_row = row_r - RW'(1);
    end
  end
  assign back_addr = AW'(32'(back_row) * COLUMNS + 32'(back_col));

  always_comb begin
    state_nxt        = state_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    sc_nxt           = sc_r;
    wv_nxt           = 1'b0;
    wa_nxt           = wa_r;
    res_scrolled_nxt = res_scrolled_r;
    res_read_nxt     = res_read_r;
    q_pop            = 1'b0;
    we               = 1'b0;
    wa               = wa_r;
    wd               = rdata_r;
    re               = 1'b0;
    ra               = '0;

    // A copied word read in the previous cycle lands here.
    if (wv_r) begin
      we = 1'b1;
    end

    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = sc_r;
        wd = {{tccw_pkg::ATTR_W{1'b0}}, tccw_pkg::CHAR_SPACE};
        if (sc_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          sc_nxt = sc_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop            = 1'b1;
          res_scrolled_nxt = 1'b0;
          res_read_nxt     = 1'b0;
          state_nxt        = ST_RESULT;
          case (q_item.kind)
            tccw_pkg::KIND_READ: begin
              res_read_nxt = (32'(q_item.cell_address) < CELLS);
              re           = 1'b1;
              ra           = AW'(q_item.cell_address);
            end
            tccw_pkg::KIND_NEWLINE: begin
              col_nxt = '0;
              if (row_r == RW'(ROWS - 1)) begin
                state_nxt        = ST_SCROLL;
                sc_nxt           = '0;
                res_scrolled_nxt = 1'b1;
              end else begin
                row_nxt = row_r + RW'(1);
              end
            end
            tccw_pkg::KIND_BACKSPACE: begin
              col_nxt = back_col;
              row_nxt = back_row;
              we      = 1'b1;
              wa      = back_addr;
              wd      = blank;
            end
            tccw_pkg::KIND_PRINT: begin
              we = 1'b1;
              wa = cur_addr;
              wd = {attribute, q_item.character};
              if (col_r == CW'(COLUMNS - 1)) begin
                col_nxt = '0;
                if (row_r == RW'(ROWS - 1)) begin
                  state_nxt        = ST_SCROLL;
                  sc_nxt           = '0;
                  res_scrolled_nxt = 1'b1;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // Read the cell one row below and write it one row up in the next cycle.
        re     = 1'b1;
        ra     = AW'(32'(sc_r) + COLUMNS);
        wv_nxt = 1'b1;
        wa_nxt = sc_r;
        if (sc_r == AW'(LAST - 1)) begin
          sc_nxt    = AW'(LAST);
          state_nxt = ST_BLANK;
        end else begin
          sc_nxt = sc_r + AW'(1);
        end
      end
      ST_BLANK: begin
        if (!wv_r) begin
          we = 1'b1;
          wa = sc_r;
          wd = blank;
          if (sc_r == AW'(CELLS - 1)) begin
            state_nxt = ST_RESULT;
          end else begin
            sc_nxt = sc_r + AW'(1);
          end
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      col_r          <= '0;
      row_r          <= '0;
      sc_r           <= '0;
      wv_r           <= 1'b0;
      res_scrolled_r <= 1'b0;
      res_read_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      sc_r           <= sc_nxt;
      wv_r           <= wv_nxt;
      res_scrolled_r <= res_scrolled_nxt;
      res_read_r     <= res_read_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wa_r <= wa_nxt;
    if (out_load) begin
      out_col_r <= tccw_pkg::COL_W'(col_r);
      out_row_r <= tccw_pkg::ROW_W'(row_r);
      out_scr_r <= res_scrolled_r;
      out_ch_r  <= res_read_r ? rdata_r[tccw_pkg::CHAR_W-1:0] : '0;
      out_at_r  <= res_read_r ? rdata_r[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_column  = out_col_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.scrolled       = out_scr_r;
  assign out_ch.read_character = out_ch_r;
  assign out_ch.read_attribute = out_at_r;

endmodule

// ===== rtl/text_console_char_writer_core.sv =====
`timescale 1ns / 1ps

// Text console writer over a COLUMNS x ROWS grid of character cells. A put
// word, a NUL or a read word is handled in the back end by acting on the
// cell store and then registering the result word. A put that scrolls
// also runs a copy sweep that moves each row up by one and a blank sweep
// of the last row, one cell per cycle through the store's one write
// port. After reset a clearing pass writes every cell, and no input word is
// taken until it ends. A two-word queue sits between the front end and the
// back end; the attribute registers on the APB port are to be written only
// while the block is idle.
module text_console_char_writer_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  tccw_in_if.sink     in_ch,
  tccw_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]        bg_r, bg_nxt;
  logic [3:0]        fg_r, fg_nxt;
  logic              cfg_write;
  logic              hold_off;
  logic              q_valid;
  logic              q_pop;
  tccw_pkg::q_item_t q_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    bg_nxt = bg_r;
    fg_nxt = fg_r;
    if (cfg_write) begin
      case (paddr[2])
        tccw_pkg::REG_BACKGROUND: bg_nxt = pwdata[3:0];
        tccw_pkg::REG_FOREGROUND: fg_nxt = pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tccw_pkg::REG_BACKGROUND: prdata = {28'd0, bg_r};
      tccw_pkg::REG_FOREGROUND: prdata = {28'd0, fg_r};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= 4'd0;
      fg_r <= 4'd7;
    end else begin
      bg_r <= bg_nxt;
      fg_r <= fg_nxt;
    end
  end

  tccw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .hold_off (hold_off),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .attribute ({bg_r, fg_r}),
    .clearing  (hold_off),
    .out_ch    (out_ch)
  );

endmodule
